// File: hdl/optical_flow_frame_parser_macros.svh
// assertion macros shared by the optical flow frame parser rtl
// no dependencies; the asserting modules need clk and rst_n in scope
`ifndef OPTICAL_FLOW_FRAME_PARSER_MACROS_SVH
`define OPTICAL_FLOW_FRAME_PARSER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define OFP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ofp assertion failed");
// next-cycle implication, checked out of reset
`define OFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ofp assertion failed");
`else
`define OFP_ASSERT_IMPL(lbl, ante, cons)
`define OFP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/ofp_pkg.sv
// types, constants and helpers for the optical flow frame parser
// no dependencies; imported by every module of the block
package ofp_pkg;

  localparam int FRAME_LENGTH = 11;
  localparam int POS_W        = $clog2(FRAME_LENGTH);
  localparam int PAYLOAD_LEN  = 6;

  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t POS_HUNT      = pos_t'(0);
  localparam pos_t POS_PROTO     = pos_t'(1);
  localparam pos_t POS_PAY_FIRST = pos_t'(2);
  localparam pos_t POS_PAY_LAST  = pos_t'(POS_PAY_FIRST + PAYLOAD_LEN - 1);
  localparam pos_t POS_CHECKSUM  = pos_t'(POS_PAY_LAST + 1);
  localparam pos_t POS_QUALITY   = pos_t'(POS_CHECKSUM + 1);
  localparam pos_t POS_FOOTER    = pos_t'(FRAME_LENGTH - 1);

  localparam logic [7:0] HEADER_MARK   = 8'hFE;
  localparam logic [7:0] PROTOCOL_MARK = 8'h04;
  localparam logic [7:0] FOOTER_RESET  = 8'hAA;

  typedef struct packed {
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic [15:0]        distance_cm;
    logic [7:0]         quality;
  } frame_t;

  // times ten as two shifted adds
  function automatic logic [19:0] cm_to_mm(input logic [15:0] cm);
    logic [19:0] wide;
    wide = {4'b0, cm};
    return (wide << 3) + (wide << 1);
  endfunction

endpackage

// File: hdl/ofp_byte_reg.sv
// input register for received bytes, with stall back to the sender
// depends on ofp_pkg
module ofp_byte_reg
  import ofp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       can_load,
  output logic       fire,
  output logic [7:0] rx_byte
);

  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  logic       load;

  assign fire     = vld_r && can_load;
  assign load     = !vld_r || fire;
  assign in_stall = !load;
  assign rx_byte  = byte_r;

  always_comb begin
    vld_nxt = load ? in_valid : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

// File: hdl/ofp_frame_track.sv
// frame position tracking, payload capture and checksum for one byte a cycle while fire is high
// depends on ofp_pkg and the assertion macro header
`include "optical_flow_frame_parser_macros.svh"

module ofp_frame_track
  import ofp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  input  logic [7:0] footer,
  output logic       hit,
  output frame_t     frame
);

  pos_t       pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] pay_r [PAYLOAD_LEN];
  logic [7:0] chk_r;
  logic [7:0] qual_r;

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (fire) begin
      if (pos_r == POS_HUNT) begin
        if (rx_byte == HEADER_MARK) begin
          pos_nxt = POS_PROTO;
          sum_nxt = 8'd0;
        end
      end else if (pos_r == POS_PROTO) begin
        sum_nxt = 8'd0;
        if (rx_byte == PROTOCOL_MARK) begin
          pos_nxt = POS_PAY_FIRST;
        end else if (rx_byte == HEADER_MARK) begin
          pos_nxt = POS_PROTO;
        end else begin
          pos_nxt = POS_HUNT;
        end
      end else if (pos_r <= POS_PAY_LAST) begin
        sum_nxt = sum_r + rx_byte;
        pos_nxt = pos_r + pos_t'(1);
      end else if (pos_r == POS_CHECKSUM || pos_r == POS_QUALITY) begin
        pos_nxt = pos_r + pos_t'(1);
      end else begin
        // footer byte, or a position past the frame
        pos_nxt = POS_HUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
      sum_r <= 8'd0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      if (fire && pos_r == pos_t'(POS_PAY_FIRST + i)) begin
        pay_r[i] <= rx_byte;
      end
    end
    if (fire && pos_r == POS_CHECKSUM) begin
      chk_r <= rx_byte;
    end
    if (fire && pos_r == POS_QUALITY) begin
      qual_r <= rx_byte;
    end
  end

  assign hit = fire && pos_r == POS_FOOTER && rx_byte == footer && chk_r == sum_r;

  always_comb begin
    frame.flow_x      = {pay_r[1], pay_r[0]};
    frame.flow_y      = {pay_r[3], pay_r[2]};
    frame.distance_cm = {pay_r[5], pay_r[4]};
    frame.quality     = qual_r;
  end

  `OFP_ASSERT_IMPL(a_pos_in_frame, 1'b1, pos_r <= POS_FOOTER)
  `OFP_ASSERT_IMPL(a_hit_on_footer, hit, pos_r == POS_FOOTER)
  `OFP_ASSERT_NEXT(a_footer_rehunts, fire && pos_r == POS_FOOTER, pos_r == POS_HUNT)

endmodule

// File: hdl/ofp_out_reg.sv
// result register: unit conversion and output hold under stall
// depends on ofp_pkg
module ofp_out_reg
  import ofp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               hit,
  input  frame_t             frame,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_flow_x,
  output logic signed [15:0] out_flow_y,
  output logic [19:0]        out_distance_mm,
  output logic [7:0]         out_surface_quality
);

  logic               vld_r, vld_nxt;
  logic signed [15:0] fx_r, fy_r;
  logic [19:0]        dist_r;
  logic [7:0]         qual_r;

  assign can_load = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = can_load ? hit : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && hit) begin
      fx_r   <= frame.flow_x;
      fy_r   <= frame.flow_y;
      dist_r <= cm_to_mm(frame.distance_cm);
      qual_r <= frame.quality;
    end
  end

  assign out_valid           = vld_r;
  assign out_flow_x          = fx_r;
  assign out_flow_y          = fy_r;
  assign out_distance_mm     = dist_r;
  assign out_surface_quality = qual_r;

endmodule

// File: hdl/optical_flow_frame_parser.sv
// top level of the optical flow frame parser: footer register and stage wiring
// depends on ofp_pkg, ofp_byte_reg, ofp_frame_track and ofp_out_reg
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   in_rx_byte
//   out_     output     out_valid/out_stall flow x, flow y, distance mm, quality
//   cfg_     input      cfg_valid/cfg_ready cfg_footer_byte
//
// one byte a cycle sustained while out_stall is low; a byte is held in the byte register
// and parsed from there, and a frame result appears on the outputs on the cycle after its footer is parsed
// the byte register and the result register are the registers on that path
// synchronous active-low reset returns to header hunt and sets the footer to 0xaa
// an out_stall holds the result; the byte register stalls only when a result is held
module optical_flow_frame_parser
  import ofp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // received bytes
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  // decoded frames
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_flow_x,
  output logic signed [15:0] out_flow_y,
  output logic [19:0]        out_distance_mm,
  output logic [7:0]         out_surface_quality,
  // footer marker register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_footer_byte
);

  logic [7:0] footer_r;
  logic       can_load;
  logic       fire;
  logic [7:0] rx_byte;
  logic       hit;
  frame_t     frame;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      footer_r <= FOOTER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      footer_r <= cfg_footer_byte;
    end
  end

  // stage one: hold the received byte
  ofp_byte_reg u_byte_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .can_load   (can_load),
    .fire       (fire),
    .rx_byte    (rx_byte)
  );

  // stage two: advance the frame position, capture fields, check the frame
  ofp_frame_track u_frame_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .rx_byte (rx_byte),
    .footer  (footer_r),
    .hit     (hit),
    .frame   (frame)
  );

  // result register, distance scaled to millimetres on the way in
  ofp_out_reg u_out_reg (
    .clk                 (clk),
    .rst_n               (rst_n),
    .hit                 (hit),
    .frame               (frame),
    .can_load            (can_load),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_flow_x          (out_flow_x),
    .out_flow_y          (out_flow_y),
    .out_distance_mm     (out_distance_mm),
    .out_surface_quality (out_surface_quality)
  );

endmodule

// File: dv/ofp_frame_checker.sv
`timescale 1ns / 1ps
// frame checker for the optical flow frame parser: watches all three channels,
// decodes the accepted byte stream itself and compares every decoded frame
// depends on ofp_pkg for the position codes and the frame marks
module ofp_frame_checker
  import ofp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_flow_x,
  input  logic signed [15:0] out_flow_y,
  input  logic [19:0]        out_distance_mm,
  input  logic [7:0]         out_surface_quality,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_footer_byte,
  input  logic               end_of_test,
  output int                 frames_pending,
  output int                 fail_count
);

  typedef struct {
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic [19:0]        distance_mm;
    logic [7:0]         quality;
  } flow_frame_t;

  flow_frame_t frames_due[$];

  pos_t       position;
  logic [7:0] payload[PAYLOAD_LEN];
  logic [7:0] checksum_byte;
  logic [7:0] quality_byte;
  logic [7:0] byte_sum;
  logic [7:0] footer_mark;
  int         mismatches = 0;
  bit         leftovers_checked = 1'b0;

  assign fail_count = mismatches;

  task automatic report(input string what);
    $display("%0t: %s", $realtime, what);
    mismatches++;
  endtask

  // advance the frame tracker by one byte, queue a frame when one completes
  task automatic parse_byte(input logic [7:0] b);
    flow_frame_t f;
    if (position == POS_HUNT) begin
      if (b == HEADER_MARK) begin
        position = POS_PROTO;
        byte_sum = '0;
      end
    end else if (position == POS_PROTO) begin
      if (b == PROTOCOL_MARK) position = POS_PAY_FIRST;
      else if (b == HEADER_MARK) position = POS_PROTO;
      else position = POS_HUNT;
      byte_sum = '0;
    end else if (position >= POS_PAY_FIRST && position <= POS_PAY_LAST) begin
      payload[position - POS_PAY_FIRST] = b;
      byte_sum = byte_sum + b;
      position = position + 1'b1;
    end else if (position == POS_CHECKSUM) begin
      checksum_byte = b;
      position = POS_QUALITY;
    end else if (position == POS_QUALITY) begin
      quality_byte = b;
      position = POS_FOOTER;
    end else begin
      // footer byte, or a position past the frame
      if (position == POS_FOOTER && b == footer_mark && checksum_byte == byte_sum) begin
        f.flow_x      = {payload[1], payload[0]};
        f.flow_y      = {payload[3], payload[2]};
        f.distance_mm = {4'b0, payload[5], payload[4]} * 20'd10;
        f.quality     = quality_byte;
        frames_due.push_back(f);
      end
      position = POS_HUNT;
    end
  endtask

  always @(posedge clk) begin : watch
    flow_frame_t due;
    if (!rst_n) begin
      position    = POS_HUNT;
      byte_sum    = '0;
      footer_mark = FOOTER_RESET;
      frames_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) footer_mark = cfg_footer_byte;
      if (out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          report($sformatf("frame with no byte stream behind it: x %0d y %0d mm %0d q %0d",
                           out_flow_x, out_flow_y, out_distance_mm, out_surface_quality));
        end else begin
          due = frames_due.pop_front();
          if (out_flow_x !== due.flow_x)
            report($sformatf("flow_x %0d, wanted %0d", out_flow_x, due.flow_x));
          if (out_flow_y !== due.flow_y)
            report($sformatf("flow_y %0d, wanted %0d", out_flow_y, due.flow_y));
          if (out_distance_mm !== due.distance_mm)
            report($sformatf("distance_mm %0d, wanted %0d", out_distance_mm, due.distance_mm));
          if (out_surface_quality !== due.quality)
            report($sformatf("quality %0d, wanted %0d", out_surface_quality, due.quality));
        end
      end
      if (in_valid && !in_stall) parse_byte(in_rx_byte);
      if (end_of_test && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (frames_due.size() != 0)
          report($sformatf("%0d frames never came out", frames_due.size()));
      end
    end
    frames_pending = frames_due.size();
  end

endmodule

// File: dv/optical_flow_frame_parser_tb.sv
`timescale 1ns / 1ps
// top of the optical flow frame parser testbench: clock, reset, byte stimulus
// and verdict; depends on ofp_pkg, ofp_frame_checker and the parser rtl
module optical_flow_frame_parser_tb;
  import ofp_pkg::*;

  // how a generated frame is spoilt, if at all
  typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_FOOTER} frame_flaw_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_rx_byte;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_flow_x;
  logic signed [15:0] out_flow_y;
  logic [19:0]        out_distance_mm;
  logic [7:0]         out_surface_quality;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_footer_byte;
  logic               end_of_test;
  int                 frames_pending;
  int                 fail_count;

  // idling mix: sender gap and receiver stall, percent of cycles
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  logic [7:0] footer_now = FOOTER_RESET;

  // the four idling modes, selected by index
  int send_pct_tab[4]  = '{0, 51, 0, 31};
  int stall_pct_tab[4] = '{0, 0, 51, 31};

  always #5 clk = ~clk;

  optical_flow_frame_parser DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_flow_x          (out_flow_x),
    .out_flow_y          (out_flow_y),
    .out_distance_mm     (out_distance_mm),
    .out_surface_quality (out_surface_quality),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_footer_byte     (cfg_footer_byte)
  );

  ofp_frame_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_flow_x          (out_flow_x),
    .out_flow_y          (out_flow_y),
    .out_distance_mm     (out_distance_mm),
    .out_surface_quality (out_surface_quality),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_footer_byte     (cfg_footer_byte),
    .end_of_test         (end_of_test),
    .frames_pending      (frames_pending),
    .fail_count          (fail_count)
  );

  // receiver back-pressure, redrawn every cycle at the current rate
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  function automatic void pick_mode(input int m);
    send_idle_pct = send_pct_tab[m];
    stall_pct     = stall_pct_tab[m];
  endfunction

  // random words half the time, the extremes the other half
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one byte transaction, with random sender gaps ahead of it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // a full frame, or only its first len bytes when cut short
  task automatic send_frame(input logic [15:0] fx, input logic [15:0] fy,
                            input logic [15:0] cm, input logic [7:0] qual,
                            input frame_flaw_t flaw, input int len);
    logic [7:0] bytes[FRAME_LENGTH];
    logic [7:0] sum;
    sum = '0;
    bytes[0] = HEADER_MARK;
    bytes[1] = PROTOCOL_MARK;
    bytes[2] = fx[7:0];
    bytes[3] = fx[15:8];
    bytes[4] = fy[7:0];
    bytes[5] = fy[15:8];
    bytes[6] = cm[7:0];
    bytes[7] = cm[15:8];
    for (int i = 2; i < 8; i++) sum = sum + bytes[i];
    // a spoilt byte always differs from the right one
    bytes[8]  = (flaw == FRAME_BAD_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum;
    bytes[9]  = qual;
    bytes[10] = (flaw == FRAME_BAD_FOOTER) ? footer_now ^ 8'($urandom_range(1, 255))
                                           : footer_now;
    for (int i = 0; i < len; i++) send_byte(bytes[i]);
  endtask

  // wait until every frame is out, then let the two-stage pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (frames_pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_footer(input logic [7:0] v);
    settle();
    cfg_valid       <= 1'b1;
    cfg_footer_byte <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    footer_now  = v;
  endtask

  // random traffic until about target frame bytes have gone in
  task automatic random_traffic(input int target, input bit mix_modes);
    int sent;
    int kind;
    int n;
    sent = 0;
    while (sent < target) begin
      if (mix_modes) pick_mode($urandom_range(0, 3));
      kind = $urandom_range(0, 19);
      if (kind < 13) begin
        send_frame(pick_word(), pick_word(), pick_word(), 8'(pick_word()),
                   FRAME_GOOD, FRAME_LENGTH);
        sent += FRAME_LENGTH;
      end else if (kind < 15) begin
        send_frame(pick_word(), pick_word(), pick_word(), 8'(pick_word()),
                   FRAME_BAD_SUM, FRAME_LENGTH);
        sent += FRAME_LENGTH;
      end else if (kind < 17) begin
        send_frame(pick_word(), pick_word(), pick_word(), 8'(pick_word()),
                   FRAME_BAD_FOOTER, FRAME_LENGTH);
        sent += FRAME_LENGTH;
      end else if (kind == 17) begin
        // header then a wrong id, which may itself be another header
        send_byte(HEADER_MARK);
        n = $urandom_range(0, 255);
        if (n == PROTOCOL_MARK) n = HEADER_MARK;
        send_byte(8'(n));
        sent += 2;
      end else if (kind == 18) begin
        // frame cut short; the following bytes land in its remaining positions
        n = $urandom_range(2, FRAME_LENGTH - 1);
        send_frame(pick_word(), pick_word(), pick_word(), 8'(pick_word()),
                   FRAME_GOOD, n);
        sent += n;
      end else begin
        // line noise between frames
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_rx_byte      <= '0;
    cfg_valid       <= 1'b0;
    cfg_footer_byte <= '0;
    end_of_test     <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: noise while hunting, a wrong protocol id, a repeated header,
    // then a frame of extreme values and one with a bad checksum
    send_byte(8'h00);
    send_byte(HEADER_MARK);
    send_byte(8'h05);
    send_byte(HEADER_MARK);
    send_frame(16'h8000, 16'h7FFF, 16'hFFFF, 8'hFF, FRAME_GOOD, FRAME_LENGTH);
    send_frame(16'h7FFF, 16'h8000, 16'h0000, 8'h00, FRAME_BAD_SUM, FRAME_LENGTH);

    // random phases, each under its own footer and idling mix
    write_footer(8'h00);
    pick_mode(0);
    random_traffic(210, 1'b0);

    write_footer(8'hFF);
    pick_mode(1);
    random_traffic(210, 1'b0);

    write_footer(8'($urandom_range(0, 255)));
    pick_mode(2);
    random_traffic(210, 1'b0);

    // footer equal to the header mark
    write_footer(HEADER_MARK);
    pick_mode(3);
    random_traffic(210, 1'b0);

    // back to the reset value, idling mix changing from frame to frame
    write_footer(FOOTER_RESET);
    random_traffic(210, 1'b1);

    settle();
    stall_pct    = 0;
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
